// ----- hw/rtl/lsbp_pkg.sv -----
// Shared types and constants of the LSB-first bit packer.
`default_nettype none
package lsbp_pkg;

	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned VALUE_W = 24;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned POS_W   = 17;
	localparam int unsigned IDX_W   = 16;
	localparam int unsigned PEND_W  = 7;
	localparam int unsigned PCNT_W  = 3;
	localparam int unsigned ACC_W   = 31;
	localparam int unsigned NB_W    = 2;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	localparam logic REG_OUT_CAPACITY = 1'b0;

	localparam logic [COUNT_W-1:0] MAX_GROUP_BITS = 5'd24;
	localparam logic [POS_W-1:0]   POSITION_LIMIT = 17'd65536;
	localparam logic [POS_W-1:0]   CAPACITY_RESET = 17'd65536;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] bit_count;
	} req_t;

	typedef struct packed {
		logic [7:0]       byte_value;
		logic [IDX_W-1:0] byte_index;
		logic [POS_W-1:0] bytes_written;
		logic             last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_bytes;
		logic left_one;
		logic slot_free;
		logic full;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lsb_first_bit_packer_top.sv -----
// Top level of the LSB-first bit packer: register port, controller and datapath.
//
// Usage:
//   req channel (req_valid/req_stall/req) takes one transaction per command:
//   write bits, flush pending bits, or restart the stream. rsp channel
//   (rsp_valid/rsp_stall/rsp) returns one transaction per stored byte, with
//   its buffer index, the running byte count and last on the final byte of
//   a command. The APB port holds out_capacity at byte address 0.
// Timing:
//   A command that completes n bytes (0 to 3) keeps the block busy after
//   acceptance: the controller enters its emit state and sends one byte per
//   cycle through the output register while rsp is not stalled, and takes no
//   new command until the last byte is sent or dropped. Each byte reaches rsp
//   from the output register.
// Stall:
//   While rsp is stalled the output register holds its transaction and the
//   sequencer waits; bytes beyond the capacity are dropped without waiting.
// Reset:
//   Clears position and pending bits, and sets out_capacity to 65536.
`default_nettype none
module lsb_first_bit_packer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire lsbp_pkg::req_t                req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output lsbp_pkg::rsp_t                     rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lsbp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [lsbp_pkg::DATA_W-1:0]   pwdata,
	output logic [lsbp_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	logic [lsbp_pkg::POS_W-1:0] cap_q;
	logic [lsbp_pkg::POS_W-1:0] limit;
	lsbp_pkg::ctrl_cmd_t        cmd;
	lsbp_pkg::dp_sts_t          sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == lsbp_pkg::REG_OUT_CAPACITY) ?
		{{(lsbp_pkg::DATA_W - lsbp_pkg::POS_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lsbp_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == lsbp_pkg::REG_OUT_CAPACITY)) begin
			cap_q <= pwdata[lsbp_pkg::POS_W-1:0];
		end
	end

	assign limit = cap_q[lsbp_pkg::POS_W-1] ? lsbp_pkg::POSITION_LIMIT : cap_q;

	lsbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lsbp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.limit     (limit),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_count_follows_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.bytes_written == ({1'b0, rsp.byte_index} + 1'b1)))
		else $error("bytes_written does not follow byte_index");

	a_restart_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (req.func == lsbp_pkg::FUNC_RESTART)) |=> !req_stall)
		else $error("restart left the packer busy");

	a_write_short_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (req.func == lsbp_pkg::FUNC_WRITE)
			&& (req.bit_count == '0)) |=> !req_stall)
		else $error("zero-length write left the packer busy");

endmodule
`default_nettype wire

// ----- hw/rtl/lsbp_ctrl.sv -----
// Controller state machine of the LSB-first bit packer.
`default_nettype none
module lsbp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire lsbp_pkg::dp_sts_t sts,
	output lsbp_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign cmd.load  = accept;
	assign cmd.step  = (state_q == S_EMIT) && (sts.slot_free || sts.full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && sts.has_bytes) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (cmd.step && sts.left_one) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lsbp_dp.sv -----
// Datapath of the LSB-first bit packer: accumulator, position and output register.
`default_nettype none
module lsbp_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lsbp_pkg::req_t               req,
	input  wire logic [lsbp_pkg::POS_W-1:0]   limit,
	input  wire lsbp_pkg::ctrl_cmd_t          cmd,
	output lsbp_pkg::dp_sts_t                 sts,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output lsbp_pkg::rsp_t                    rsp
);

	logic [lsbp_pkg::ACC_W-1:0]   acc_q;
	logic [lsbp_pkg::NB_W-1:0]    left_q;
	logic [lsbp_pkg::PEND_W-1:0]  pend_q;
	logic [lsbp_pkg::PCNT_W-1:0]  pcnt_q;
	logic [lsbp_pkg::POS_W-1:0]   pos_q;
	logic                         rsp_valid_q;
	lsbp_pkg::rsp_t               rsp_q;

	logic [lsbp_pkg::COUNT_W-1:0] count_c;
	logic [lsbp_pkg::VALUE_W-1:0] masked_c;
	logic [lsbp_pkg::ACC_W-1:0]   acc_c;
	logic [lsbp_pkg::COUNT_W-1:0] total_c;
	logic [lsbp_pkg::NB_W-1:0]    nb_c;
	logic [lsbp_pkg::PEND_W-1:0]  rem_c;
	logic [lsbp_pkg::POS_W-1:0]   pos_next_c;
	logic                         emit_c;
	logic                         has_bytes_c;

	assign count_c  = (req.bit_count > lsbp_pkg::MAX_GROUP_BITS) ?
		lsbp_pkg::MAX_GROUP_BITS : req.bit_count;
	assign masked_c = req.value & ~({lsbp_pkg::VALUE_W{1'b1}} << count_c);
	assign acc_c    = {{(lsbp_pkg::ACC_W - lsbp_pkg::PEND_W){1'b0}}, pend_q}
		| ({{(lsbp_pkg::ACC_W - lsbp_pkg::VALUE_W){1'b0}}, masked_c} << pcnt_q);
	assign total_c  = {{(lsbp_pkg::COUNT_W - lsbp_pkg::PCNT_W){1'b0}}, pcnt_q} + count_c;
	assign nb_c     = total_c[4:3];

	always_comb begin
		case (nb_c)
			2'd0:    rem_c = acc_c[6:0];
			2'd1:    rem_c = acc_c[14:8];
			2'd2:    rem_c = acc_c[22:16];
			default: rem_c = acc_c[30:24];
		endcase
	end

	always_comb begin
		case (req.func)
			lsbp_pkg::FUNC_WRITE: has_bytes_c = (nb_c != '0);
			lsbp_pkg::FUNC_FLUSH: has_bytes_c = (pcnt_q != '0);
			default:              has_bytes_c = 1'b0;
		endcase
	end

	assign sts.has_bytes = has_bytes_c;
	assign pos_next_c    = pos_q + 1'b1;
	assign sts.left_one  = (left_q == 2'd1);
	assign sts.slot_free = !rsp_valid_q || !rsp_stall;
	assign sts.full      = (pos_q >= limit);
	assign emit_c        = cmd.step && !sts.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			pend_q      <= '0;
			pcnt_q      <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				case (req.func)
					lsbp_pkg::FUNC_WRITE: begin
						left_q <= nb_c;
						pend_q <= rem_c;
						pcnt_q <= total_c[2:0];
					end
					lsbp_pkg::FUNC_FLUSH: begin
						left_q <= {1'b0, (pcnt_q != '0)};
						pend_q <= '0;
						pcnt_q <= '0;
					end
					lsbp_pkg::FUNC_RESTART: begin
						left_q <= '0;
						pend_q <= '0;
						pcnt_q <= '0;
						pos_q  <= '0;
					end
					default: ;
				endcase
			end else if (cmd.step) begin
				left_q <= left_q - 1'b1;
				if (emit_c) begin
					pos_q <= pos_next_c;
				end
			end
			if (emit_c) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (req.func == lsbp_pkg::FUNC_FLUSH) begin
				acc_q <= {{(lsbp_pkg::ACC_W - lsbp_pkg::PEND_W){1'b0}}, pend_q};
			end else begin
				acc_q <= acc_c;
			end
		end else if (cmd.step) begin
			acc_q <= {8'd0, acc_q[lsbp_pkg::ACC_W-1:8]};
		end
		if (emit_c) begin
			rsp_q.byte_value    <= acc_q[7:0];
			rsp_q.byte_index    <= pos_q[lsbp_pkg::IDX_W-1:0];
			rsp_q.bytes_written <= pos_next_c;
			rsp_q.last          <= sts.left_one || (pos_next_c >= limit);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the LSB-first bit packer top level.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [lsbp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 120;
	localparam int REPORT_LIMIT  = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	lsbp_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	lsbp_pkg::rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [lsbp_pkg::ADDR_W-1:0] paddr = '0;
	logic [lsbp_pkg::DATA_W-1:0] pwdata = '0;
	logic [lsbp_pkg::DATA_W-1:0] prdata;
	logic pready;

	lsb_first_bit_packer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// packer state as predicted from the accepted commands
	logic [lsbp_pkg::PEND_W-1:0] pk_bits = '0;
	logic [lsbp_pkg::PCNT_W-1:0] pk_cnt = '0;
	logic [lsbp_pkg::POS_W-1:0]  pk_pos = '0;
	logic [lsbp_pkg::POS_W-1:0]  pk_cap = lsbp_pkg::CAPACITY_RESET;

	lsbp_pkg::req_t cmd_q[$];
	lsbp_pkg::rsp_t exp_bytes[$];

	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_dropped = 0;
	int n_flush = 0;
	int n_restart = 0;
	int n_cfg = 0;
	int n_errors = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit idle_en = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("lsb_first_bit_packer_top regression: fail");
		$finish;
	end

	function automatic void flag_error(input string msg);
		n_errors++;
		if (n_errors <= REPORT_LIMIT)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic bit try_store(input logic [7:0] b, output lsbp_pkg::rsp_t r);
		logic [lsbp_pkg::POS_W-1:0] lim;
		lim = (pk_cap > lsbp_pkg::POSITION_LIMIT) ? lsbp_pkg::POSITION_LIMIT : pk_cap;
		r = '0;
		if (pk_pos >= lim) begin
			n_dropped++;
			return 1'b0;
		end
		r.byte_value = b;
		r.byte_index = pk_pos[lsbp_pkg::IDX_W-1:0];
		pk_pos = pk_pos + 1'b1;
		r.bytes_written = pk_pos;
		return 1'b1;
	endfunction

	function automatic void pack_cmd(input lsbp_pkg::req_t c);
		lsbp_pkg::rsp_t outs[3];
		lsbp_pkg::rsp_t r;
		logic [lsbp_pkg::COUNT_W-1:0] n;
		logic [lsbp_pkg::VALUE_W:0] mask;
		logic [lsbp_pkg::ACC_W-1:0] acc;
		int total;
		int made;
		int k;
		made = 0;
		case (c.func)
			lsbp_pkg::FUNC_WRITE: begin
				n = (c.bit_count > lsbp_pkg::MAX_GROUP_BITS) ?
					lsbp_pkg::MAX_GROUP_BITS : c.bit_count;
				mask = ({{lsbp_pkg::VALUE_W{1'b0}}, 1'b1} << n) - 1'b1;
				acc = lsbp_pkg::ACC_W'(pk_bits)
					| (lsbp_pkg::ACC_W'(c.value & mask[lsbp_pkg::VALUE_W-1:0]) << pk_cnt);
				total = int'(pk_cnt) + int'(n);
				while (total >= 8) begin
					if (try_store(acc[7:0], r)) begin
						outs[made] = r;
						made++;
					end
					acc = acc >> 8;
					total -= 8;
				end
				pk_bits = acc[lsbp_pkg::PEND_W-1:0];
				pk_cnt = lsbp_pkg::PCNT_W'(total);
			end
			lsbp_pkg::FUNC_FLUSH: begin
				n_flush++;
				if (pk_cnt != 0 && try_store({1'b0, pk_bits}, r)) begin
					outs[made] = r;
					made++;
				end
				pk_bits = '0;
				pk_cnt = '0;
			end
			lsbp_pkg::FUNC_RESTART: begin
				n_restart++;
				pk_pos = '0;
				pk_bits = '0;
				pk_cnt = '0;
			end
			default: ;
		endcase
		for (k = 0; k < made; k++) begin
			if (k == made - 1)
				outs[k].last = 1'b1;
			exp_bytes.push_back(outs[k]);
		end
	endfunction

	function automatic void check_byte(input lsbp_pkg::rsp_t got);
		lsbp_pkg::rsp_t want;
		if (exp_bytes.size() == 0) begin
			flag_error($sformatf("unexpected byte %02h index %0d count %0d last %0b",
				got.byte_value, got.byte_index, got.bytes_written, got.last));
			return;
		end
		want = exp_bytes.pop_front();
		n_checked++;
		if (got.byte_value !== want.byte_value || got.byte_index !== want.byte_index ||
				got.bytes_written !== want.bytes_written || got.last !== want.last)
			flag_error($sformatf({"byte mismatch: expected value %02h index %0d count %0d ",
				"last %0b, got value %02h index %0d count %0d last %0b"},
				want.byte_value, want.byte_index, want.bytes_written, want.last,
				got.byte_value, got.byte_index, got.bytes_written, got.last));
	endfunction

	// command driver
	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			pack_cmd(req);
			n_accepted++;
		end
		if (!req_valid || !req_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				if (idle_en && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 2);
					req_valid <= 1'b0;
				end else begin
					req <= cmd_q.pop_front();
					req_valid <= 1'b1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// byte monitor and output stall
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			check_byte(rsp);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send(input logic [lsbp_pkg::FUNC_W-1:0] f,
			input logic [lsbp_pkg::VALUE_W-1:0] v,
			input logic [lsbp_pkg::COUNT_W-1:0] cnt);
		lsbp_pkg::req_t c;
		c.func = f;
		c.value = v;
		c.bit_count = cnt;
		cmd_q.push_back(c);
		n_queued++;
	endtask

	task automatic send_random(input int num);
		lsbp_pkg::req_t c;
		int sel;
		repeat (num) begin
			sel = $urandom_range(0, 99);
			c.value = lsbp_pkg::VALUE_W'($urandom);
			c.bit_count = lsbp_pkg::COUNT_W'($urandom_range(0, 24));
			if (sel < 8)
				c.bit_count = lsbp_pkg::COUNT_W'($urandom_range(25, 31));
			c.func = lsbp_pkg::FUNC_WRITE;
			if (sel >= 84 && sel < 94)
				c.func = lsbp_pkg::FUNC_FLUSH;
			else if (sel >= 94 && sel < 97)
				c.func = lsbp_pkg::FUNC_RESTART;
			else if (sel >= 97)
				c.func = FUNC_UNUSED;
			cmd_q.push_back(c);
			n_queued++;
		end
	endtask

	task automatic drain();
		while (n_accepted != n_queued || exp_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cap_write(input logic [lsbp_pkg::POS_W-1:0] v);
		logic [lsbp_pkg::DATA_W-1:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= lsbp_pkg::ADDR_W'({lsbp_pkg::REG_OUT_CAPACITY, 2'b00});
		pwdata <= lsbp_pkg::DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pk_cap = v;
		n_cfg++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[lsbp_pkg::POS_W-1:0] !== v)
			flag_error($sformatf("out_capacity readback: expected %0d, got %0d", v,
				rd[lsbp_pkg::POS_W-1:0]));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(lsbp_pkg::FUNC_WRITE, 24'hFFFFFF, 5'd0);
		send(lsbp_pkg::FUNC_WRITE, 24'hFFFFFF, 5'd24);
		send(lsbp_pkg::FUNC_FLUSH, 24'h000000, 5'd0);
		send(lsbp_pkg::FUNC_WRITE, 24'hFFFFFD, 5'd3);
		send(lsbp_pkg::FUNC_WRITE, 24'hA5C3E1, 5'd24);
		send(lsbp_pkg::FUNC_WRITE, 24'h123456, 5'd31);
		send(lsbp_pkg::FUNC_WRITE, 24'h00ABCD, 5'd25);
		send(lsbp_pkg::FUNC_FLUSH, 24'h000000, 5'd0);
		send(FUNC_UNUSED, 24'hFFFFFF, 5'd24);
		send(lsbp_pkg::FUNC_WRITE, 24'h00007F, 5'd7);
		send(lsbp_pkg::FUNC_WRITE, 24'h000001, 5'd1);
		send(lsbp_pkg::FUNC_WRITE, 24'hFFFF00, 5'd8);
		send(lsbp_pkg::FUNC_WRITE, 24'h0000FF, 5'd8);
		send(lsbp_pkg::FUNC_WRITE, 24'h000015, 5'd5);
		send(lsbp_pkg::FUNC_RESTART, 24'hFFFFFF, 5'd31);
		send(lsbp_pkg::FUNC_WRITE, 24'h0000C3, 5'd8);
		send(lsbp_pkg::FUNC_WRITE, 24'h001ABC, 5'd13);
		send(lsbp_pkg::FUNC_FLUSH, 24'hFFFFFF, 5'd31);
		send(lsbp_pkg::FUNC_WRITE, 24'h7FFFFF, 5'd23);
		send(lsbp_pkg::FUNC_WRITE, 24'h000001, 5'd1);
		send(lsbp_pkg::FUNC_WRITE, 24'h800000, 5'd24);
		send(lsbp_pkg::FUNC_RESTART, 24'h000000, 5'd0);
		drain();

		cap_write(17'd10);
		send_random(10);
		send(lsbp_pkg::FUNC_RESTART, 24'h000000, 5'd0);
		send_random(30);
		drain();

		cap_write(17'd1);
		send(lsbp_pkg::FUNC_RESTART, 24'h000000, 5'd0);
		send_random(6);
		drain();

		cap_write(17'd0);
		send(lsbp_pkg::FUNC_RESTART, 24'h000000, 5'd0);
		send_random(6);
		drain();

		// hold off the output so the block backs up into its input
		cap_write(17'h1FFFF);
		hold_req = 1'b1;
		@(posedge clk);
		send(lsbp_pkg::FUNC_RESTART, 24'h000000, 5'd0);
		send_random(110);
		drain();

		idle_en = 1'b0;
		cap_write(17'd65535);
		send_random(80);
		drain();

		cap_write(17'd8);
		send_random(20);
		drain();

		$display("Ran %0d commands (%0d flushes, %0d restarts) over %0d capacity settings.",
			n_accepted, n_flush, n_restart, n_cfg);
		$display("Checked %0d output bytes; %0d bytes fell beyond capacity.", n_checked,
			n_dropped);
		if (n_errors == 0)
			$display("lsb_first_bit_packer_top regression: pass");
		else
			$display("lsb_first_bit_packer_top regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/lsbp_pkg.sv
hw/rtl/lsbp_ctrl.sv
hw/rtl/lsbp_dp.sv
hw/rtl/lsb_first_bit_packer_top.sv
bench/tb_top.sv
